// File: hdl/ppr_pkg.sv
// Shared types, fixed-point constants and helper functions for the position
// phase PI regulator. No dependencies; every other file of the block uses it.
package ppr_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;             // stream fields and held references
    localparam int CFG_W  = 31;             // configuration registers
    localparam int ERR_W  = DATA_W + 1;     // errors, room for a negated minimum
    localparam int SUM_W  = ERR_W + 1;      // integral plus error
    localparam int RAMP_W = DATA_W + 2;     // reference plus or minus step

    // Gains and limits, rounded to nearest at FRAC_BITS
    localparam longint KP_ROT_Q   = 64'sd60 <<< FRAC_BITS;
    localparam longint KI_ROT_Q   = 64'sd20 <<< FRAC_BITS;
    localparam longint KP_TRAN_Q  = ((64'sd36 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam longint KI_TRAN_Q  = ((64'sd64 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam longint ROT_I_LIM  = ((64'sd24 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam longint TRAN_I_LIM = ((64'sd24 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam longint ROT_STEP   = ((64'sd32 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam longint TRAN_STEP  = ((64'sd36 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam longint HALF_PI    =
        ((64'sd1570796327 <<< FRAC_BITS) + 64'sd500000000) / 64'sd1000000000;

    // Configuration reset values
    localparam longint RST_LIN_LIM   = 64'sd1 <<< FRAC_BITS;
    localparam longint RST_ANG_LIM   = 64'sd3 <<< FRAC_BITS;
    localparam longint RST_EPS_SMALL = ((64'sd1 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam longint RST_EPS_ROT   = ((64'sd5 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam longint RST_EPS_MED   = ((64'sd5 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam longint RST_EPS_BIG   = ((64'sd1 <<< FRAC_BITS) + 64'sd1) / 64'sd2;

    // Coefficient and product widths; KP_ROT is the largest coefficient
    localparam int K_W      = $clog2(KP_ROT_Q + 1) + 1;
    localparam int ROT_I_W  = $clog2(ROT_I_LIM + 1) + 1;
    localparam int TRAN_I_W = $clog2(TRAN_I_LIM + 1) + 1;
    localparam int PROD_W   = K_W + ERR_W;
    localparam int PID_W    = PROD_W - FRAC_BITS + 1;

    localparam logic signed [K_W-1:0]    C_KP_ROT     = K_W'(KP_ROT_Q);
    localparam logic signed [K_W-1:0]    C_KI_ROT     = K_W'(KI_ROT_Q);
    localparam logic signed [K_W-1:0]    C_KP_TRAN    = K_W'(KP_TRAN_Q);
    localparam logic signed [K_W-1:0]    C_KI_TRAN    = K_W'(KI_TRAN_Q);
    localparam logic signed [SUM_W-1:0]  C_ROT_I_LIM  = SUM_W'(ROT_I_LIM);
    localparam logic signed [SUM_W-1:0]  C_TRAN_I_LIM = SUM_W'(TRAN_I_LIM);
    localparam logic signed [RAMP_W-1:0] C_ROT_STEP   = RAMP_W'(ROT_STEP);
    localparam logic signed [RAMP_W-1:0] C_TRAN_STEP  = RAMP_W'(TRAN_STEP);
    localparam logic        [ERR_W-1:0]  C_HALF_PI    = ERR_W'(HALF_PI);
    localparam logic signed [RAMP_W-1:0] C_SAT_HI     = RAMP_W'(64'sd2147483647);
    localparam logic signed [RAMP_W-1:0] C_SAT_LO     = RAMP_W'(-64'sd2147483648);

    // Stream layout
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;
    localparam int MOVING_BIT  = 3 * DATA_W;
    localparam int PHASE_LSB   = 2 * DATA_W;

    // APB
    localparam int ADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CLR_ROT,
        OP_CLR_TRAN,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        PH_ROT_ANGLE,
        PH_ROT_POS,
        PH_TRAN_ROT,
        PH_TRAN
    } t_phase;

    typedef enum logic [2:0] {
        REG_LIN_LIM,
        REG_ANG_LIM,
        REG_EPS_SMALL,
        REG_EPS_ROT,
        REG_EPS_MED,
        REG_EPS_BIG
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] lin_lim;
        logic [CFG_W-1:0] ang_lim;
        logic [CFG_W-1:0] eps_small;
        logic [CFG_W-1:0] eps_rot;
        logic [CFG_W-1:0] eps_med;
        logic [CFG_W-1:0] eps_big;
    } t_cfg;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] dist_err;
        logic signed [DATA_W-1:0] head_err_pos;
        logic signed [DATA_W-1:0] head_err_final;
        logic                     moving;
    } t_item;

    // Stage 2 to stage 3: which laws run, the phase to report and the raw products
    typedef struct packed {
        logic                     do_rot;
        logic                     do_tran;
        logic                     half;
        logic                     lin_zero;
        logic                     ang_zero;
        t_phase                   phase;
        logic signed [PROD_W-1:0] rot_p;
        logic signed [PROD_W-1:0] rot_i;
        logic signed [PROD_W-1:0] tran_p;
        logic signed [PROD_W-1:0] tran_i;
    } t_law;

    function automatic logic signed [SUM_W-1:0] f_clamp_int(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_clamp_pid(
        input logic signed [PID_W-1:0] v,
        input logic        [CFG_W-1:0] lim
    );
        logic signed [PID_W-1:0] lim_s;
        logic signed [PID_W-1:0] r;
        lim_s = $signed(PID_W'(lim));
        if (v > lim_s) begin
            r = lim_s;
        end else if (v < -lim_s) begin
            r = -lim_s;
        end else begin
            r = v;
        end
        return DATA_W'(r);
    endfunction

    // Move cur toward tgt by at most step, then saturate to 32-bit signed
    function automatic logic signed [DATA_W-1:0] f_ramp(
        input logic signed [DATA_W-1:0] cur,
        input logic signed [DATA_W-1:0] tgt,
        input logic signed [RAMP_W-1:0] step
    );
        logic signed [RAMP_W-1:0] c;
        logic signed [RAMP_W-1:0] t;
        logic signed [RAMP_W-1:0] up;
        logic signed [RAMP_W-1:0] dn;
        logic signed [RAMP_W-1:0] r;
        c  = RAMP_W'(cur);
        t  = RAMP_W'(tgt);
        up = c + step;
        dn = c - step;
        if (t > up) begin
            r = up;
        end else if (t < dn) begin
            r = dn;
        end else begin
            r = t;
        end
        if (r > C_SAT_HI) begin
            r = C_SAT_HI;
        end else if (r < C_SAT_LO) begin
            r = C_SAT_LO;
        end
        return DATA_W'(r);
    endfunction

endpackage

// File: hdl/ppr_cfg.sv
// APB register file for the six limit and threshold registers.
// Depends on ppr_pkg.
module ppr_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppr_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppr_pkg::PDATA_W-1:0]  pwdata,
    output logic [ppr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output ppr_pkg::t_cfg                o_cfg
);

    ppr_pkg::t_cfg    r_cfg;
    ppr_pkg::t_reg_idx idx;
    logic             wr_en;
    logic [ppr_pkg::CFG_W-1:0] wdata;

    assign pready = 1'b1;
    assign idx    = ppr_pkg::t_reg_idx'(paddr[ppr_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign wdata  = pwdata[ppr_pkg::CFG_W-1:0];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lin_lim   <= ppr_pkg::CFG_W'(ppr_pkg::RST_LIN_LIM);
            r_cfg.ang_lim   <= ppr_pkg::CFG_W'(ppr_pkg::RST_ANG_LIM);
            r_cfg.eps_small <= ppr_pkg::CFG_W'(ppr_pkg::RST_EPS_SMALL);
            r_cfg.eps_rot   <= ppr_pkg::CFG_W'(ppr_pkg::RST_EPS_ROT);
            r_cfg.eps_med   <= ppr_pkg::CFG_W'(ppr_pkg::RST_EPS_MED);
            r_cfg.eps_big   <= ppr_pkg::CFG_W'(ppr_pkg::RST_EPS_BIG);
        end else if (wr_en) begin
            unique case (idx)
                ppr_pkg::REG_LIN_LIM:   r_cfg.lin_lim   <= wdata;
                ppr_pkg::REG_ANG_LIM:   r_cfg.ang_lim   <= wdata;
                ppr_pkg::REG_EPS_SMALL: r_cfg.eps_small <= wdata;
                ppr_pkg::REG_EPS_ROT:   r_cfg.eps_rot   <= wdata;
                ppr_pkg::REG_EPS_MED:   r_cfg.eps_med   <= wdata;
                ppr_pkg::REG_EPS_BIG:   r_cfg.eps_big   <= wdata;
                default: ;              // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ppr_pkg::REG_LIN_LIM:   prdata = {1'b0, r_cfg.lin_lim};
            ppr_pkg::REG_ANG_LIM:   prdata = {1'b0, r_cfg.ang_lim};
            ppr_pkg::REG_EPS_SMALL: prdata = {1'b0, r_cfg.eps_small};
            ppr_pkg::REG_EPS_ROT:   prdata = {1'b0, r_cfg.eps_rot};
            ppr_pkg::REG_EPS_MED:   prdata = {1'b0, r_cfg.eps_med};
            ppr_pkg::REG_EPS_BIG:   prdata = {1'b0, r_cfg.eps_big};
            default:                prdata = '0;
        endcase
    end

endmodule

// File: hdl/ppr_ctl.sv
// Stage 2: phase machine, integral state and the four gain products.
// Depends on ppr_pkg.
module ppr_ctl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ppr_pkg::t_item i_item,
    input  ppr_pkg::t_cfg  i_cfg,
    output ppr_pkg::t_law  o_law
);

    ppr_pkg::t_phase r_phase;
    ppr_pkg::t_phase n_phase;
    logic signed [ppr_pkg::ROT_I_W-1:0]  r_rot_int;
    logic signed [ppr_pkg::ROT_I_W-1:0]  n_rot_int;
    logic signed [ppr_pkg::TRAN_I_W-1:0] r_tran_int;
    logic signed [ppr_pkg::TRAN_I_W-1:0] n_tran_int;
    ppr_pkg::t_law r_law;
    ppr_pkg::t_law n_law;

    logic signed [ppr_pkg::ERR_W-1:0] d_x;
    logic signed [ppr_pkg::ERR_W-1:0] tp_x;
    logic signed [ppr_pkg::ERR_W-1:0] ta_x;
    logic signed [ppr_pkg::ERR_W-1:0] terr;
    logic signed [ppr_pkg::ERR_W-1:0] rot_err;
    logic        [ppr_pkg::ERR_W-1:0] ad;
    logic        [ppr_pkg::ERR_W-1:0] atp;
    logic        [ppr_pkg::ERR_W-1:0] eps_s;
    logic        [ppr_pkg::ERR_W-1:0] eps_s2;
    logic        [ppr_pkg::ERR_W-1:0] eps_r;
    logic        [ppr_pkg::ERR_W-1:0] eps_r2;
    logic        [ppr_pkg::ERR_W-1:0] eps_m;
    logic        [ppr_pkg::ERR_W-1:0] eps_b;
    logic signed [ppr_pkg::SUM_W-1:0] rot_sum;
    logic signed [ppr_pkg::SUM_W-1:0] tran_sum;
    logic do_rot;
    logic do_tran;
    logic half;
    logic lin_zero;
    logic ang_zero;
    logic still;

    always_comb begin
        d_x  = ppr_pkg::ERR_W'(i_item.dist_err);
        tp_x = ppr_pkg::ERR_W'(i_item.head_err_pos);
        ta_x = ppr_pkg::ERR_W'(i_item.head_err_final);
        ad   = d_x[ppr_pkg::ERR_W-1]  ? -d_x  : d_x;
        atp  = tp_x[ppr_pkg::ERR_W-1] ? -tp_x : tp_x;

        eps_s  = ppr_pkg::ERR_W'(i_cfg.eps_small);
        eps_s2 = {eps_s[ppr_pkg::ERR_W-2:0], 1'b0};
        eps_r  = ppr_pkg::ERR_W'(i_cfg.eps_rot);
        eps_r2 = {eps_r[ppr_pkg::ERR_W-2:0], 1'b0};
        eps_m  = ppr_pkg::ERR_W'(i_cfg.eps_med);
        eps_b  = ppr_pkg::ERR_W'(i_cfg.eps_big);

        // facing away from the target: drive backward
        terr  = (atp > ppr_pkg::C_HALF_PI) ? -d_x : d_x;
        still = !i_item.moving;

        n_phase  = r_phase;
        do_rot   = 1'b0;
        do_tran  = 1'b0;
        half     = 1'b0;
        lin_zero = 1'b0;
        ang_zero = 1'b0;
        rot_err  = tp_x;

        if (i_item.op == ppr_pkg::OP_TICK) begin
            unique case (r_phase)
                ppr_pkg::PH_ROT_ANGLE: begin
                    if (ad > eps_s2 && still) begin
                        n_phase = ppr_pkg::PH_ROT_POS;
                    end else if (ad > eps_s && still) begin
                        n_phase = ppr_pkg::PH_TRAN;
                    end
                    rot_err  = ta_x;
                    do_rot   = 1'b1;
                    lin_zero = 1'b1;
                end
                ppr_pkg::PH_ROT_POS: begin
                    if (atp < eps_m && still) begin
                        n_phase = ppr_pkg::PH_TRAN_ROT;
                    end
                    do_rot   = 1'b1;
                    lin_zero = 1'b1;
                end
                ppr_pkg::PH_TRAN_ROT: begin
                    // later test wins
                    if (ad < eps_r) begin
                        n_phase = ppr_pkg::PH_TRAN;
                    end
                    if (atp > eps_b) begin
                        n_phase = ppr_pkg::PH_ROT_POS;
                    end
                    do_tran = 1'b1;
                    do_rot  = 1'b1;
                    half    = 1'b1;
                end
                ppr_pkg::PH_TRAN: begin
                    if (ad < eps_s && still) begin
                        n_phase = ppr_pkg::PH_ROT_ANGLE;
                    end
                    if (ad > eps_r2) begin
                        n_phase = ppr_pkg::PH_ROT_POS;
                    end
                    do_tran  = 1'b1;
                    ang_zero = 1'b1;
                end
                default: ;
            endcase
        end

        rot_sum    = ppr_pkg::SUM_W'(r_rot_int) + ppr_pkg::SUM_W'(rot_err);
        tran_sum   = ppr_pkg::SUM_W'(r_tran_int) + ppr_pkg::SUM_W'(terr);
        n_rot_int  = ppr_pkg::ROT_I_W'(ppr_pkg::f_clamp_int(rot_sum, ppr_pkg::C_ROT_I_LIM));
        n_tran_int = ppr_pkg::TRAN_I_W'(ppr_pkg::f_clamp_int(tran_sum, ppr_pkg::C_TRAN_I_LIM));

        n_law.do_rot   = do_rot;
        n_law.do_tran  = do_tran;
        n_law.half     = half;
        n_law.lin_zero = lin_zero;
        n_law.ang_zero = ang_zero;
        n_law.phase    = n_phase;
        n_law.rot_p    = ppr_pkg::C_KP_ROT * rot_err;
        n_law.rot_i    = ppr_pkg::C_KI_ROT * ppr_pkg::ERR_W'(n_rot_int);
        n_law.tran_p   = ppr_pkg::C_KP_TRAN * terr;
        n_law.tran_i   = ppr_pkg::C_KI_TRAN * ppr_pkg::ERR_W'(n_tran_int);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ppr_pkg::PH_ROT_ANGLE;
            r_rot_int  <= '0;
            r_tran_int <= '0;
        end else if (i_load) begin
            r_phase <= n_phase;
            if (i_item.op == ppr_pkg::OP_CLR_ROT) begin
                r_rot_int <= '0;
            end else if (do_rot) begin
                r_rot_int <= n_rot_int;
            end
            if (i_item.op == ppr_pkg::OP_CLR_TRAN) begin
                r_tran_int <= '0;
            end else if (do_tran) begin
                r_tran_int <= n_tran_int;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_law <= n_law;
        end
    end

    assign o_law = r_law;

endmodule

// File: hdl/ppr_out.sv
// Stage 3: PI sums, output clamps, step limit and the held speed references,
// which double as the result register. Depends on ppr_pkg.
module ppr_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  ppr_pkg::t_law                      i_law,
    input  ppr_pkg::t_cfg                      i_cfg,
    output logic signed [ppr_pkg::DATA_W-1:0]  o_lin_ref,
    output logic signed [ppr_pkg::DATA_W-1:0]  o_ang_ref,
    output ppr_pkg::t_phase                    o_phase
);

    logic signed [ppr_pkg::DATA_W-1:0] r_lin;
    logic signed [ppr_pkg::DATA_W-1:0] n_lin;
    logic signed [ppr_pkg::DATA_W-1:0] r_ang;
    logic signed [ppr_pkg::DATA_W-1:0] n_ang;
    ppr_pkg::t_phase                   r_phase;

    logic signed [ppr_pkg::PID_W-1:0]  rot_pid;
    logic signed [ppr_pkg::PID_W-1:0]  tran_pid;
    logic signed [ppr_pkg::DATA_W-1:0] rot_tgt;
    logic signed [ppr_pkg::DATA_W-1:0] tran_tgt;
    logic signed [ppr_pkg::DATA_W-1:0] rot_new;
    logic signed [ppr_pkg::DATA_W-1:0] rot_held;
    logic signed [ppr_pkg::DATA_W-1:0] tran_new;

    always_comb begin
        // products round toward minus infinity
        rot_pid  = ppr_pkg::PID_W'(i_law.rot_p >>> ppr_pkg::FRAC_BITS)
                 + ppr_pkg::PID_W'(i_law.rot_i >>> ppr_pkg::FRAC_BITS);
        tran_pid = ppr_pkg::PID_W'(i_law.tran_p >>> ppr_pkg::FRAC_BITS)
                 + ppr_pkg::PID_W'(i_law.tran_i >>> ppr_pkg::FRAC_BITS);

        rot_tgt  = ppr_pkg::f_clamp_pid(rot_pid, i_cfg.ang_lim);
        tran_tgt = ppr_pkg::f_clamp_pid(tran_pid, i_cfg.lin_lim);

        rot_new  = ppr_pkg::f_ramp(r_ang, rot_tgt, ppr_pkg::C_ROT_STEP);
        tran_new = ppr_pkg::f_ramp(r_lin, tran_tgt, ppr_pkg::C_TRAN_STEP);
        rot_held = i_law.half ? (rot_new >>> 1) : rot_new;

        if (i_law.do_rot) begin
            n_ang = rot_held;
        end else if (i_law.ang_zero) begin
            n_ang = '0;
        end else begin
            n_ang = r_ang;
        end

        if (i_law.do_tran) begin
            n_lin = tran_new;
        end else if (i_law.lin_zero) begin
            n_lin = '0;
        end else begin
            n_lin = r_lin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin   <= '0;
            r_ang   <= '0;
            r_phase <= ppr_pkg::PH_ROT_ANGLE;
        end else if (i_load) begin
            r_lin   <= n_lin;
            r_ang   <= n_ang;
            r_phase <= i_law.phase;
        end
    end

    assign o_lin_ref = r_lin;
    assign o_ang_ref = r_ang;
    assign o_phase   = r_phase;

endmodule

// File: hdl/position_phase_pi_regulator.sv
// Top level of the position phase PI regulator: input register, stage
// control and result stream. Depends on ppr_pkg, ppr_cfg, ppr_ctl, ppr_out.
//
// Usage:
//   Input stream: one transaction per control tick (or integral clear op).
//   tuser carries the op code, tdata the distance, the two heading errors
//   and the moving flag. Output stream: one transaction per input
//   transaction, in order, with the held linear and angular speed
//   references and the phase after that item.
//   Pipeline: input register, phase/integral/multiply stage, PI sum and
//   step limit stage that loads the output register. Throughput: one item
//   per clock while the receiver takes results; the phase and integral
//   registers close their loop in stage 2, the held references in stage 3.
//   When the receiver stalls the output holds; the two inner stages keep
//   filling, and tready drops once all three are occupied. Each stage
//   moves on as soon as the one after it is free or draining.
//   Reset (synchronous, active low) sets phase to rotate-to-angle, clears
//   integrals, references and all stage valids, and loads the register
//   defaults. The user must write the APB registers only while the stream
//   is idle; the block itself does not enforce this.
module position_phase_pi_regulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppr_pkg::ADDR_W-1:0]          paddr,
    input  logic [ppr_pkg::PDATA_W-1:0]         pwdata,
    output logic [ppr_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] dist_err, [63:32] head_err_pos, [95:64] head_err_final,
    // [96] moving, [103:97] zero
    input  logic [ppr_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] op
    input  logic [ppr_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] lin_ref, [63:32] ang_ref, [65:64] phase_out, [71:66] zero
    output logic [ppr_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int DW = ppr_pkg::DATA_W;

    ppr_pkg::t_cfg  cfg;
    ppr_pkg::t_item r_s1_item;
    ppr_pkg::t_law  law;
    logic           r_s1_valid;
    logic           r_s2_valid;
    logic           r_out_valid;
    logic           s1_adv;
    logic           s2_adv;
    logic           s3_adv;
    logic signed [DW-1:0] lin_ref;
    logic signed [DW-1:0] ang_ref;
    ppr_pkg::t_phase      phase;

    // each stage advances when the next one is empty or moving on
    assign s3_adv = !r_out_valid || i_m_axis_tready;
    assign s2_adv = !r_s2_valid || s3_adv;
    assign s1_adv = !r_s1_valid || s2_adv;

    assign o_s_axis_tready = s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_item.op             <= ppr_pkg::t_op'(i_s_axis_tuser[1:0]);
            r_s1_item.dist_err       <= i_s_axis_tdata[DW-1:0];
            r_s1_item.head_err_pos   <= i_s_axis_tdata[2*DW-1:DW];
            r_s1_item.head_err_final <= i_s_axis_tdata[3*DW-1:2*DW];
            r_s1_item.moving         <= i_s_axis_tdata[ppr_pkg::MOVING_BIT];
        end
    end

    ppr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppr_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_s1_valid && s2_adv),
        .i_item  (r_s1_item),
        .i_cfg   (cfg),
        .o_law   (law)
    );

    ppr_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_s2_valid && s3_adv),
        .i_law     (law),
        .i_cfg     (cfg),
        .o_lin_ref (lin_ref),
        .o_ang_ref (ang_ref),
        .o_phase   (phase)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, phase, ang_ref, lin_ref};

endmodule

// File: hdl/ppr_chk.sv
// Port-level checker for position_phase_pi_regulator, bound to the top level.
// Depends on ppr_pkg.
module ppr_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [ppr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    ppr_pkg::t_phase r_last_phase;
    ppr_pkg::t_phase out_phase;
    logic            out_xfer;

    assign out_phase = ppr_pkg::t_phase'(o_m_axis_tdata[ppr_pkg::PHASE_LSB+1:ppr_pkg::PHASE_LSB]);
    assign out_xfer  = o_m_axis_tvalid && i_m_axis_tready;

    // phase reported by the last result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= ppr_pkg::PH_ROT_ANGLE;
        end else if (out_xfer) begin
            r_last_phase <= out_phase;
        end
    end

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked while output stage empty");

    // only the phase moves the machine allows between consecutive results
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |->
            !(r_last_phase == ppr_pkg::PH_ROT_ANGLE && out_phase == ppr_pkg::PH_TRAN_ROT) &&
            !(r_last_phase == ppr_pkg::PH_ROT_POS &&
              (out_phase == ppr_pkg::PH_ROT_ANGLE || out_phase == ppr_pkg::PH_TRAN)) &&
            !(r_last_phase == ppr_pkg::PH_TRAN_ROT && out_phase == ppr_pkg::PH_ROT_ANGLE) &&
            !(r_last_phase == ppr_pkg::PH_TRAN && out_phase == ppr_pkg::PH_TRAN_ROT))
        else $error("illegal phase change");

endmodule

bind position_phase_pi_regulator ppr_chk u_ppr_chk (.*);

// File: tb/sv/tb_position_phase_pi_regulator.sv
// Self-checking testbench for position_phase_pi_regulator: drives random and directed control
// ticks over the input stream, predicts every result transaction and checks it in order.
// Depends on ppr_pkg and the regulator RTL.
`timescale 1ns / 1ps

module tb_position_phase_pi_regulator;

    import ppr_pkg::*;

    localparam int FRAC = ppr_pkg::FRAC_BITS;

    // Gains, limits and steps rounded to nearest at FRAC fraction bits
    localparam longint GAIN_KP_ROT  = 64'sd60 <<< FRAC;
    localparam longint GAIN_KI_ROT  = 64'sd20 <<< FRAC;
    localparam longint GAIN_KP_TRAN = ((64'sd36 <<< FRAC) + 64'sd500) / 64'sd1000;
    localparam longint GAIN_KI_TRAN = ((64'sd64 <<< FRAC) + 64'sd50) / 64'sd100;
    localparam longint LIM_ROT_INT  = ((64'sd24 <<< FRAC) + 64'sd50) / 64'sd100;
    localparam longint LIM_TRAN_INT = ((64'sd24 <<< FRAC) + 64'sd5) / 64'sd10;
    localparam longint STEP_ROT     = ((64'sd32 <<< FRAC) + 64'sd5) / 64'sd10;
    localparam longint STEP_TRAN    = ((64'sd36 <<< FRAC) + 64'sd50) / 64'sd100;
    localparam longint QUARTER_TURN =
        ((64'sd1570796327 <<< FRAC) + 64'sd500000000) / 64'sd1000000000;

    typedef struct packed {
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        t_phase             ph;
    } t_refs;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]      pwdata = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]   i_s_axis_tuser = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;

    position_phase_pi_regulator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Regulator shadow state
    longint limits [6] = '{64'sd1 <<< FRAC, 64'sd3 <<< FRAC,
                           ((64'sd1 <<< FRAC) + 64'sd50) / 64'sd100,
                           ((64'sd5 <<< FRAC) + 64'sd50) / 64'sd100,
                           ((64'sd5 <<< FRAC) + 64'sd50) / 64'sd100,
                           64'sd1 <<< (FRAC - 1)};
    t_phase  cur_phase = PH_ROT_ANGLE;
    longint  rot_int   = 0;
    longint  tran_int  = 0;
    longint  lin_held  = 0;
    longint  ang_held  = 0;

    t_item   tick_q[$];
    t_refs   expected_refs[$];
    t_item   cur_item;
    int      tx_gap = 0;
    int      rx_gap = 0;
    bit      tx_idle = 1'b0;
    bit      rx_idle = 1'b0;
    bit      hold_go = 1'b0;
    logic    rx_hold = 1'b0;
    int      err_cnt = 0;
    int      res_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------
    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Step limit toward the target, then hold within 32-bit signed
    function automatic longint step_toward(longint cur, longint tgt, longint step);
        longint r;
        if (tgt > cur + step) r = cur + step;
        else if (tgt < cur - step) r = cur - step;
        else r = tgt;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic void rot_law(longint err, bit half);
        longint pi_sum;
        rot_int  = clamp_sym(rot_int + err, LIM_ROT_INT);
        pi_sum   = ((GAIN_KP_ROT * err) >>> FRAC) + ((GAIN_KI_ROT * rot_int) >>> FRAC);
        pi_sum   = clamp_sym(pi_sum, limits[REG_ANG_LIM]);
        ang_held = step_toward(ang_held, pi_sum, STEP_ROT);
        if (half) ang_held = ang_held >>> 1;
    endfunction

    function automatic void tran_law(longint err);
        longint pi_sum;
        tran_int = clamp_sym(tran_int + err, LIM_TRAN_INT);
        pi_sum   = ((GAIN_KP_TRAN * err) >>> FRAC) + ((GAIN_KI_TRAN * tran_int) >>> FRAC);
        pi_sum   = clamp_sym(pi_sum, limits[REG_LIN_LIM]);
        lin_held = step_toward(lin_held, pi_sum, STEP_TRAN);
    endfunction

    function automatic t_refs regulate_step(t_item it);
        longint d, tp, ta, ad, atp, terr;
        longint eps_s, eps_r, eps_m, eps_b;
        t_refs  r;
        d     = $signed(it.dist_err);
        tp    = $signed(it.head_err_pos);
        ta    = $signed(it.head_err_final);
        ad    = (d < 0) ? -d : d;
        atp   = (tp < 0) ? -tp : tp;
        eps_s = limits[REG_EPS_SMALL];
        eps_r = limits[REG_EPS_ROT];
        eps_m = limits[REG_EPS_MED];
        eps_b = limits[REG_EPS_BIG];
        // facing away from the target: drive backward
        terr  = (atp > QUARTER_TURN) ? -d : d;
        case (it.op)
            OP_CLR_ROT:  rot_int = 0;
            OP_CLR_TRAN: tran_int = 0;
            OP_TICK: begin
                // the law of the phase held on entry runs, whatever the next phase is
                case (cur_phase)
                    PH_ROT_ANGLE: begin
                        if (ad > 2 * eps_s && !it.moving) cur_phase = PH_ROT_POS;
                        else if (ad > eps_s && !it.moving) cur_phase = PH_TRAN;
                        rot_law(ta, 1'b0);
                        lin_held = 0;
                    end
                    PH_ROT_POS: begin
                        if (atp < eps_m && !it.moving) cur_phase = PH_TRAN_ROT;
                        rot_law(tp, 1'b0);
                        lin_held = 0;
                    end
                    PH_TRAN_ROT: begin
                        if (ad < eps_r) cur_phase = PH_TRAN;
                        if (atp > eps_b) cur_phase = PH_ROT_POS;
                        tran_law(terr);
                        rot_law(tp, 1'b1);
                    end
                    default: begin
                        if (ad < eps_s && !it.moving) cur_phase = PH_ROT_ANGLE;
                        if (ad > 2 * eps_r) cur_phase = PH_ROT_POS;
                        tran_law(terr);
                        ang_held = 0;
                    end
                endcase
            end
            default: ;
        endcase
        r.lin = lin_held[31:0];
        r.ang = ang_held[31:0];
        r.ph  = cur_phase;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    task automatic push_tick(t_op op, logic signed [31:0] d, logic signed [31:0] tp,
                             logic signed [31:0] ta, logic mv);
        t_item it;
        it.op             = op;
        it.dist_err       = d;
        it.head_err_pos   = tp;
        it.head_err_final = ta;
        it.moving         = mv;
        tick_q.push_back(it);
    endtask

    // Magnitude clustered around two levels, random sign
    function automatic logic signed [31:0] near_level(longint a, longint b);
        longint      v;
        int unsigned cap;
        cap = (b > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(b);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       v = 0;
            2, 3, 4: v = a + longint'($urandom_range(0, 2)) - 1;
            5, 6:    v = b + longint'($urandom_range(0, 2)) - 1;
            7:       v = longint'($urandom_range(0, cap));
            default: v = longint'($urandom_range(0, 1 << 18));
        endcase
        if (v < 0) v = 0;
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if ($urandom_range(0, 1)) v = -v;
        return v[31:0];
    endfunction

    function automatic t_item rand_tick();
        t_item it;
        case ($urandom_range(0, 19))
            0:       it.op = OP_CLR_ROT;
            1:       it.op = OP_CLR_TRAN;
            2:       it.op = OP_NOP;
            default: it.op = OP_TICK;
        endcase
        if ($urandom_range(0, 1))
            it.dist_err = near_level(limits[REG_EPS_SMALL], 2 * limits[REG_EPS_SMALL]);
        else
            it.dist_err = near_level(limits[REG_EPS_ROT], 2 * limits[REG_EPS_ROT]);
        if ($urandom_range(0, 3) == 0)
            it.head_err_pos = near_level(QUARTER_TURN, limits[REG_EPS_BIG]);
        else
            it.head_err_pos = near_level(limits[REG_EPS_MED], limits[REG_EPS_BIG]);
        it.head_err_final = near_level(LIM_ROT_INT, 64'sd1 <<< FRAC);
        it.moving         = ($urandom_range(0, 9) < 3);
        return it;
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [30:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {1'($urandom_range(0, 1)), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limits[idx] = longint'(val);
    endtask

    task automatic load_limits(logic [30:0] lin, logic [30:0] ang, logic [30:0] es,
                               logic [30:0] er, logic [30:0] em, logic [30:0] eb);
        apb_write(REG_LIN_LIM, lin);
        apb_write(REG_ANG_LIM, ang);
        apb_write(REG_EPS_SMALL, es);
        apb_write(REG_EPS_ROT, er);
        apb_write(REG_EPS_MED, em);
        apb_write(REG_EPS_BIG, eb);
    endtask

    // Every item yields one result, so an empty store means the pipe is empty
    task automatic drain();
        while (tick_q.size() != 0 || i_s_axis_tvalid || expected_refs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        if (err_cnt < 100)
            $display("MISMATCH result %0d %s: got %0d want %0d", res_cnt, what, got, want);
        err_cnt++;
    endtask

    //------------------------------------------------------------------
    // Input driver
    //------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        logic offer;
        offer = i_s_axis_tvalid;
        if (!i_rst_n) begin
            offer  = 1'b0;
            tx_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_refs.push_back(regulate_step(cur_item));
                offer = 1'b0;
            end
            if (!offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (tick_q.size() > 0) begin
                    cur_item       = tick_q.pop_front();
                    i_s_axis_tdata <= {7'd0, cur_item.moving, cur_item.head_err_final,
                                       cur_item.head_err_pos, cur_item.dist_err};
                    i_s_axis_tuser <= cur_item.op;
                    offer          = 1'b1;
                    tx_gap         = tx_idle ? $urandom_range(0, 12) : 0;
                end
            end
        end
        i_s_axis_tvalid <= offer;
    end

    //------------------------------------------------------------------
    // Result monitor and receiver
    //------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic  take;
        t_refs got;
        t_refs want;
        take = 1'b0;
        if (!i_rst_n) begin
            rx_gap = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.lin = o_m_axis_tdata[31:0];
                got.ang = o_m_axis_tdata[63:32];
                got.ph  = t_phase'(o_m_axis_tdata[65:64]);
                if (expected_refs.size() == 0) begin
                    report_mismatch("unexpected transaction, phase", longint'(got.ph), -1);
                end else begin
                    want = expected_refs.pop_front();
                    if (got.lin !== want.lin) report_mismatch("lin_ref", got.lin, want.lin);
                    if (got.ang !== want.ang) report_mismatch("ang_ref", got.ang, want.ang);
                    if (got.ph !== want.ph)
                        report_mismatch("phase_out", longint'(got.ph), longint'(want.ph));
                end
                res_cnt++;
                rx_gap = rx_idle ? $urandom_range(0, 12) : 0;
            end
            if (rx_gap > 0) rx_gap--;
            else take = 1'b1;
            if (rx_hold) take = 1'b0;
        end
        i_m_axis_tready <= take;
    end

    // Long receiver stall so the pipe fills and input backpressure shows
    initial begin : holdoff
        wait (hold_go);
        repeat (20) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (200) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial begin : stimulus
        logic signed [31:0] hp;
        hp = 32'(QUARTER_TURN);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // Directed walk through all phases with reset limits
        push_tick(OP_NOP, $urandom, $urandom, $urandom, 1'b0);
        push_tick(OP_TICK, 32'sd0, 32'sd0, 32'sh7FFF_FFFF, 1'b1);
        push_tick(OP_TICK, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        push_tick(OP_CLR_ROT, $urandom, $urandom, $urandom, 1'b1);
        push_tick(OP_TICK, 32'sh7FFF_FFFF, 32'sd0, 32'sd0, 1'b1);
        push_tick(OP_TICK, 32'sh7FFF_FFFF, 32'sd100, 32'sh7FFF_FFFF, 1'b0);
        // heading just beyond a quarter turn in translation: distance negated
        push_tick(OP_TICK, 32'sh7FFF_FFFF, hp + 32'sd1, 32'sd0, 1'b0);
        push_tick(OP_TICK, 32'sd65536, 32'sd0, 32'sd0, 1'b0);
        // both exits true: the heading exit wins
        push_tick(OP_TICK, 32'sd100, -hp, 32'sd0, 1'b0);
        push_tick(OP_TICK, 32'sd65536, 32'sd0, 32'sd0, 1'b0);
        push_tick(OP_TICK, 32'sd100, 32'sd10, 32'sd0, 1'b1);
        // negating the most negative distance
        push_tick(OP_TICK, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        push_tick(OP_TICK, 32'sd65536, 32'sd0, 32'sd0, 1'b0);
        push_tick(OP_TICK, 32'sd100, 32'sd0, 32'sd0, 1'b0);
        push_tick(OP_CLR_TRAN, $urandom, $urandom, $urandom, 1'b0);
        push_tick(OP_TICK, 32'sd10, 32'sd0, 32'sh8000_0000, 1'b0);
        push_tick(OP_TICK, 32'sd1000, 32'sd0, 32'sd0, 1'b0);
        push_tick(OP_TICK, 32'sd10, 32'sd0, 32'sd0, 1'b1);
        push_tick(OP_TICK, -32'sd10, -32'sd1, 32'sd0, 1'b0);
        push_tick(OP_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd1, 1'b1);

        for (int k = 0; k < 6; k++) begin
            drain();
            case (k)
                1: load_limits('0, '0, '0, '0, '0, '0);
                2: load_limits('1, '1, '1, '1, '1, '1);
                3: load_limits(31'($urandom), 31'($urandom), 31'($urandom),
                               31'($urandom), 31'($urandom), 31'($urandom));
                4, 5: load_limits(31'($urandom_range(1 << 14, 4 << 16)),
                                  31'($urandom_range(1 << 15, 8 << 16)),
                                  31'($urandom_range(0, 2000)),
                                  31'($urandom_range(1000, 8000)),
                                  31'($urandom_range(0, 8000)),
                                  31'($urandom_range(8000, 1 << 16)));
                default: ;
            endcase
            @(negedge i_clk);
            tx_idle = (k % 4 == 0) || (k % 4 == 2);
            rx_idle = (k % 4 == 0) || (k % 4 == 3);
            if (k == 5) hold_go = 1'b1;
            repeat ((k == 0) ? 120 : 145) tick_q.push_back(rand_tick());
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/ppr_pkg.sv
hdl/ppr_cfg.sv
hdl/ppr_ctl.sv
hdl/ppr_out.sv
hdl/position_phase_pi_regulator.sv
hdl/ppr_chk.sv
tb/sv/tb_position_phase_pi_regulator.sv
